FILE: rtl/bcc_pkg.sv
// Shared types and constants for the button click classifier.
package bcc_pkg;

    localparam int unsigned CfgW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned EventW = 2;

    // Event codes on click_event
    localparam logic [EventW-1:0] EV_NONE   = 2'd0;
    localparam logic [EventW-1:0] EV_SINGLE = 2'd1;
    localparam logic [EventW-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EventW-1:0] EV_LONG   = 2'd3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DOUBLE_CLICK = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CfgW-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [CfgW-1:0] DOUBLE_CLICK_RST = 16'd400;
    localparam logic [CfgW-1:0] DEBOUNCE_RST     = 16'd50;

    localparam logic [1:0] TALLY_MAX = 2'd3;

    typedef struct packed {
        logic [CfgW-1:0] long_press_ms;
        logic [CfgW-1:0] double_click_ms;
        logic [CfgW-1:0] debounce_ms;
    } bcc_cfg_t;

endpackage

FILE: rtl/button_click_classifier_unit.sv
// Button click classifier top level: handshakes, config registers, poll and event registers.
// One poll is accepted every clock while the consumer keeps up. A poll lands in
// the input register; when the output is free or being taken, its event is
// computed from the stored press/release state and written to the output
// register, and out_valid is set. The state update is a loop from the core's
// state registers through the classifier logic and back. The output register
// lets one more poll in while the last event waits. With the output stalled
// and a poll held in the input register, in_ready stays low until out_ready
// returns.
module button_click_classifier_unit
    import bcc_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               button_down,
    input  logic [31:0]        time_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [EventW-1:0]  click_event
);

    localparam int unsigned StampW = (TIME_BITS < 32) ? TIME_BITS : 32;

    bcc_cfg_t cfg_reg;

    logic              in_valid_reg;
    logic              down_reg;
    logic [StampW-1:0] time_reg;
    logic              out_valid_reg;
    logic [EventW-1:0] event_reg;
    logic [EventW-1:0] event_next;
    logic              fire;

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms   <= LONG_PRESS_RST;
            cfg_reg.double_click_ms <= DOUBLE_CLICK_RST;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_wr_data;
                REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= cfg_wr_data;
                REG_DEBOUNCE:     cfg_reg.debounce_ms     <= cfg_wr_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            down_reg <= button_down;
            time_reg <= time_ms[StampW-1:0];
        end
        if (fire)
            event_reg <= event_next;
    end

    bcc_core #(
        .TIME_BITS (TIME_BITS),
        .STAMP_W   (StampW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (fire),
        .down       (down_reg),
        .now        (time_reg),
        .cfg        (cfg_reg),
        .event_code (event_next)
    );

    assign out_valid   = out_valid_reg;
    assign click_event = event_reg;

endmodule

FILE: rtl/bcc_core.sv
// Click classifier state and per-poll next-state / event logic.
module bcc_core
    import bcc_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned STAMP_W   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                down,
    input  logic [STAMP_W-1:0]  now,
    input  bcc_cfg_t            cfg,
    output logic [EventW-1:0]   event_code
);

    logic [STAMP_W-1:0] press_start_reg, press_start_next;
    logic [STAMP_W-1:0] release_reg, release_next;
    logic               held_reg, held_next;
    logic               long_fired_reg, long_fired_next;
    logic [1:0]         tally_reg, tally_next;

    always_comb
    begin
        logic                 done;
        logic [TIME_BITS-1:0] d_rel;
        logic [TIME_BITS-1:0] d_start;

        press_start_next = press_start_reg;
        release_next     = release_reg;
        held_next        = held_reg;
        long_fired_next  = long_fired_reg;
        tally_next       = tally_reg;
        event_code       = EV_NONE;
        done             = 1'b0;

        // new press, or a bounce right after a release
        d_rel = TIME_BITS'(now) - TIME_BITS'(release_reg);
        if (down && !held_reg)
        begin
            if (d_rel < TIME_BITS'(cfg.debounce_ms))
            begin
                // bounce: start time deliberately left alone
                held_next = 1'b1;
                done      = 1'b1;
            end
            else
            begin
                press_start_next = now;
                long_fired_next  = 1'b0;
                if (tally_reg != TALLY_MAX)
                    tally_next = tally_reg + 2'd1;
                held_next = 1'b1;
            end
        end

        d_start = TIME_BITS'(now) - TIME_BITS'(press_start_next);
        if (!done && down && !long_fired_next)
        begin
            if (d_start >= TIME_BITS'(cfg.long_press_ms))
            begin
                long_fired_next = 1'b1;
                tally_next      = 2'd0;
                held_next       = 1'b1;
                event_code      = EV_LONG;
                done            = 1'b1;
            end
        end

        if (!done && !down && held_next)
        begin
            release_next = now;
            held_next    = 1'b0;
            if (long_fired_next)
            begin
                tally_next = 2'd0;
                done       = 1'b1;
            end
        end

        // quiet window after release resolves pending clicks
        if (!done && !down && tally_next != 2'd0 &&
            (TIME_BITS'(now) - TIME_BITS'(release_next)) >=
            TIME_BITS'(cfg.double_click_ms))
        begin
            event_code = (tally_next == 2'd1) ? EV_SINGLE : EV_DOUBLE;
            tally_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_start_reg <= '0;
            release_reg     <= '0;
            held_reg        <= 1'b0;
            long_fired_reg  <= 1'b0;
            tally_reg       <= 2'd0;
        end
        else if (step)
        begin
            press_start_reg <= press_start_next;
            release_reg     <= release_next;
            held_reg        <= held_next;
            long_fired_reg  <= long_fired_next;
            tally_reg       <= tally_next;
        end
    end

endmodule

FILE: rtl/bcc_checker.sv
// Port-level checks for the button click classifier, bound to the top level.
module bcc_checker
    import bcc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [EventW-1:0] click_event
);

    // a pending event holds until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transfer");

    // the event code stays put while it waits
    a_event_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(click_event))
        else $error("click_event changed before transfer");

    // with nothing waiting at the output, a poll is always taken
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // a fresh event follows a poll transfer through the input and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("event without matching poll");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .click_event (click_event)
);

FILE: bench/tb_button_click_classifier_unit.sv
// Testbench for button_click_classifier_unit: random poll gestures checked against a local predictor.
module tb_button_click_classifier_unit;
    import bcc_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 2'd3;
    localparam int unsigned LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic        down;
        logic [31:0] stamp;
    } poll_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0]    cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               button_down = 1'b0;
    logic [31:0]        time_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [EventW-1:0]  click_event;

    button_click_classifier_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .button_down (button_down),
        .time_ms     (time_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .click_event (click_event)
    );

    always #2 clk = ~clk;

    // Predictor state and register shadow
    bcc_cfg_t    cfg_shadow = '{LONG_PRESS_RST, DOUBLE_CLICK_RST, DEBOUNCE_RST};
    logic [31:0] press_start = '0;
    logic [31:0] release_at = '0;
    logic        held = 1'b0;
    logic        long_done = 1'b0;
    logic [1:0]  tally = '0;

    poll_t             poll_queue[$];
    logic [EventW-1:0] pending_events[$];
    logic [31:0]       poll_clock = '0;
    int unsigned       polls_made = 0;
    int unsigned       mismatches = 0;
    logic              poll_taken = 1'b0;
    rx_mode_e          rx_mode = RX_ALWAYS;
    logic              tx_gapless = 1'b0;
    logic              long_hold_req = 1'b0;
    logic              long_hold_done = 1'b0;

    function automatic logic [EventW-1:0] classify_poll(input logic down, input logic [31:0] now);
        logic [31:0] since_release;
        logic [31:0] held_for;
        since_release = now - release_at;
        if (down && !held) begin
            // bounce: flag set, start time left alone
            if (since_release < {16'd0, cfg_shadow.debounce_ms}) begin
                held = 1'b1;
                return EV_NONE;
            end
            press_start = now;
            long_done = 1'b0;
            if (tally != TALLY_MAX)
                tally = tally + 2'd1;
            held = 1'b1;
        end
        held_for = now - press_start;
        if (down && !long_done && held_for >= {16'd0, cfg_shadow.long_press_ms}) begin
            long_done = 1'b1;
            tally = '0;
            held = 1'b1;
            return EV_LONG;
        end
        if (!down && held) begin
            release_at = now;
            held = 1'b0;
            if (long_done) begin
                tally = '0;
                return EV_NONE;
            end
        end
        if (tally != 0 && !down && (now - release_at) >= {16'd0, cfg_shadow.double_click_ms}) begin
            classify_poll = (tally == 2'd1) ? EV_SINGLE : EV_DOUBLE;
            tally = '0;
            return classify_poll;
        end
        return EV_NONE;
    endfunction

    // Step that lands on or next to a threshold in three of eight cases
    function automatic logic [31:0] pick_gap(input logic [CfgW-1:0] thr);
        int unsigned t;
        t = 32'(thr);
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return (t == 0) ? 32'd0 : t - 1;
            2: return t;
            3: return t + 1;
            4, 5: return $urandom_range(0, t);
            6: return t + $urandom_range(1, t + 1);
            default: return $urandom_range(1, 2 * t + 2);
        endcase
    endfunction

    task automatic push_at(input logic down, input logic [31:0] stamp);
        poll_clock = stamp;
        poll_queue.push_back('{down, stamp});
        polls_made++;
    endtask

    task automatic push_poll(input logic down, input logic [31:0] delta);
        push_at(down, poll_clock + delta);
    endtask

    task automatic queue_gestures(input int unsigned target);
        int unsigned clicks;
        while (polls_made < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    clicks = $urandom_range(1, 4);
                    for (int k = 0; k < clicks; k++) begin
                        push_poll(1'b1, $urandom_range(0, 1) ? pick_gap(cfg_shadow.debounce_ms)
                                                             : pick_gap(cfg_shadow.double_click_ms));
                        repeat ($urandom_range(0, 2))
                            push_poll(1'b1, pick_gap(cfg_shadow.long_press_ms >> 1));
                        push_poll(1'b0, pick_gap(cfg_shadow.long_press_ms >> 1));
                    end
                    push_poll(1'b0, pick_gap(cfg_shadow.double_click_ms));
                    push_poll(1'b0, pick_gap(cfg_shadow.double_click_ms));
                end
                5, 6: begin
                    push_poll(1'b1, pick_gap(cfg_shadow.debounce_ms));
                    push_poll(1'b1, pick_gap(cfg_shadow.long_press_ms));
                    push_poll(1'b1, $urandom_range(0, 3));
                    push_poll(1'b0, pick_gap(cfg_shadow.long_press_ms));
                    push_poll(1'b0, pick_gap(cfg_shadow.double_click_ms));
                end
                7: begin
                    repeat ($urandom_range(1, 3))
                        push_at(1'($urandom_range(0, 1)), $urandom);
                end
                8: poll_clock = 32'hFFFF_FFFF - $urandom_range(0, 2 * cfg_shadow.long_press_ms);
                default: push_poll(1'b0, pick_gap(cfg_shadow.double_click_ms));
            endcase
        end
    endtask

    task automatic wait_idle();
        while (poll_queue.size() != 0 || in_valid || pending_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LONG_PRESS:   cfg_shadow.long_press_ms = val;
            REG_DOUBLE_CLICK: cfg_shadow.double_click_ms = val;
            REG_DEBOUNCE:     cfg_shadow.debounce_ms = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CfgW-1:0] lp, input logic [CfgW-1:0] dc,
                             input logic [CfgW-1:0] db);
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_DOUBLE_CLICK, dc);
        write_reg(REG_DEBOUNCE, db);
    endtask

    task automatic run_phase(input int unsigned target);
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        queue_gestures(target);
        wait_idle();
    endtask

    // Sender: bursts of transfers with random gaps unless tx_gapless is set
    always @(negedge clk) begin : drive_polls
        int unsigned burst_left;
        int unsigned idle_left;
        poll_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || poll_taken) begin
            if (idle_left != 0) begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (poll_queue.size() != 0) begin
                nxt = poll_queue.pop_front();
                in_valid <= 1'b1;
                button_down <= nxt.down;
                time_ms <= nxt.stamp;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 10);
                    idle_left = tx_gapless ? 0 : $urandom_range(1, 6);
                end
                else begin
                    burst_left--;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: own stall pattern, plus one long hold-off
    always @(negedge clk) begin : drive_ready
        int unsigned hold_cnt;
        int unsigned rx_tick;
        rx_tick++;
        if (long_hold_req && !long_hold_done) begin
            out_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD_CYCLES)
                long_hold_done = 1'b1;
        end
        else begin
            case (rx_mode)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: out_ready <= (rx_tick % 7) > 2;
                default:     out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk) begin : check_events
        logic [EventW-1:0] want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_events.size() == 0) begin
                $error("click_event: transfer with nothing expected, actual %0d", click_event);
                mismatches++;
            end
            else begin
                want = pending_events.pop_front();
                if (click_event !== want) begin
                    $error("click_event: expected %0d, actual %0d", want, click_event);
                    mismatches++;
                end
            end
        end
        poll_taken = rst_n && in_valid && in_ready;
        if (poll_taken)
            pending_events.push_back(classify_poll(button_down, time_ms));
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset values: bounce quirk, long press, single, double, tally saturation, wrap
        push_at(1'b0, 32'd0);
        push_at(1'b1, 32'd10);
        push_at(1'b1, 32'd1000);
        push_at(1'b0, 32'd1100);
        push_at(1'b1, 32'd1200);
        push_at(1'b0, 32'd1300);
        push_at(1'b0, 32'd1699);
        push_at(1'b0, 32'd1700);
        push_at(1'b1, 32'd2000);
        push_at(1'b0, 32'd2050);
        push_at(1'b1, 32'd2150);
        push_at(1'b0, 32'd2200);
        push_at(1'b0, 32'd2600);
        for (int k = 0; k < 4; k++) begin
            push_at(1'b1, 32'd3000 + 120 * k);
            push_at(1'b0, 32'd3060 + 120 * k);
        end
        push_at(1'b0, 32'd3820);
        push_at(1'b1, 32'hFFFF_FFFF);
        push_at(1'b0, 32'd100);
        push_at(1'b0, 32'd500);
        wait_idle();

        // Zero double-click and debounce, longest hold time
        write_all(16'hFFFF, 16'd0, 16'd0);
        write_reg(REG_UNMAPPED, CfgW'($urandom_range(0, 65535)));
        push_poll(1'b1, 32'd1);
        push_poll(1'b0, 32'd1);
        push_poll(1'b1, 32'd0);
        run_phase(polls_made + 60);

        // Zero hold time, longest windows
        write_all(16'd0, 16'hFFFF, 16'hFFFF);
        push_poll(1'b0, 32'd1);
        push_poll(1'b1, 32'd70000);
        run_phase(polls_made + 60);

        // Receiver holds off long enough to back up the input
        write_all(CfgW'($urandom_range(5, 300)), CfgW'($urandom_range(0, 150)),
                  CfgW'($urandom_range(0, 40)));
        long_hold_req = 1'b1;
        run_phase(polls_made + 140);

        write_all(CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)),
                  CfgW'($urandom_range(0, 65535)));
        run_phase(polls_made + 120);

        // No idling on either side
        write_all(CfgW'($urandom_range(5, 300)), CfgW'($urandom_range(0, 150)),
                  CfgW'($urandom_range(0, 40)));
        tx_gapless = 1'b1;
        queue_gestures(polls_made + 140);
        rx_mode = RX_ALWAYS;
        wait_idle();

        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("tb_button_click_classifier_unit OK");
        else
            $display("tb_button_click_classifier_unit NOT OK");
        $finish;
    end

    initial begin
        #800000;
        $display("tb_button_click_classifier_unit NOT OK");
        $finish;
    end

endmodule
